// File: sv/swm_pkg.sv
`default_nettype none
package swm_pkg;

   // CSR port geometry: one 32-bit register, word index in paddr[2]
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // register word index
   typedef enum logic [0:0] {
      REG_WINDOW_SIZE = 1'b0,
      REG_UNUSED      = 1'b1
   } csr_reg_type;

   function automatic csr_reg_type csr_decode(input csr_addr_type addr);
      return csr_reg_type'(addr[2]);
   endfunction

endpackage
`default_nettype wire

// File: sv/swm_if.sv
`default_nettype none
// sample channel
interface swm_req_if #(parameter int SAMPLE_BITS = 16) (input wire logic clock);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last_sample;

   modport source (input clock, output valid, input ready, output sample, output last_sample);
   modport sink   (input clock, input valid, output ready, input sample, input last_sample);
endinterface

// result channel
interface swm_rsp_if #(parameter int SAMPLE_BITS = 16) (input wire logic clock);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] window_max;
   logic                          last_result;

   modport source (input clock, output valid, input ready, output window_max,
                   output last_result);
   modport sink   (input clock, input valid, output ready, input window_max,
                   input last_result);
endinterface
`default_nettype wire

// File: sv/sliding_window_maximum.sv
`default_nettype none
// Channel   Dir  Beat fields                  Handshake
// req_chan  in   sample, last_sample          valid/ready
// rsp_chan  out  window_max, last_result      valid/ready
// csr_*     in   window_size (word 0)         APB read/write, pready tied high
//
// One sample beat per cycle unless a held result stalls the input; the
// result is registered as the sample is taken. The chain's WINDOW_MAX cells
// all update per accepted beat, so only the output register sets throughput.
// Synchronous reset clears the sequence count, the output valid and sets the
// window size to 1; cell contents need no reset (only slots filled in the
// current sequence are ever selected).
// req_chan.ready drops only while a result waits and rsp_chan.ready is low.
module sliding_window_maximum #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   swm_req_if.sink                    req_chan,
   swm_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire swm_pkg::csr_addr_type csr_paddr,
   input  wire swm_pkg::csr_data_type csr_pwdata,
   output swm_pkg::csr_data_type      csr_prdata,
   output logic                       csr_pready
);
   import swm_pkg::*;

   localparam int CNT_W = $clog2(WINDOW_MAX+1);
   localparam int IDX_W = $clog2(WINDOW_MAX);
   localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic [CNT_W-1:0] window_size;

   // sequence bookkeeping
   logic [CNT_W-1:0] seen_ff;
   logic [CNT_W-1:0] seen_in;
   logic [CNT_W-1:0] seen_sat;
   logic [CNT_W-1:0] take_cnt;
   logic [CNT_W-1:0] take_idx;
   logic [IDX_W-1:0] sel;
   logic             full_window;
   logic             emit;
   logic             accept;

   // result register
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_max_ff;
   logic                          rsp_last_ff;

   // chain taps: cell k holds max of the newest k+1 samples
   logic signed [SAMPLE_BITS-1:0] cell_max [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] cell_next [WINDOW_MAX];

   swm_csr #(.WINDOW_MAX(WINDOW_MAX)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .window_size (window_size)
   );
   assign csr_pready = 1'b1;

   // output register frees up as soon as the sink takes the held beat
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // each accepted sample ripples every cell's max one slot to the right,
   // folding in the new sample on the way
   for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
      if (k == 0) begin : g_head
         swm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .clock    (clock),
            .shift_en (accept),
            .sample   (req_chan.sample),
            .left_max (SMIN),
            .max_in   (cell_next[k]),
            .max_ff   (cell_max[k])
         );
      end else begin : g_body
         swm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .clock    (clock),
            .shift_en (accept),
            .sample   (req_chan.sample),
            .left_max (cell_max[k-1]),
            .max_in   (cell_next[k]),
            .max_ff   (cell_max[k])
         );
      end
   end

   // count saturates at WINDOW_MAX; short sequences read the tap that covers
   // everything seen so far, full windows read tap window_size-1
   always_comb begin
      seen_sat    = (seen_ff == CNT_W'(WINDOW_MAX)) ? seen_ff : seen_ff + CNT_W'(1);
      full_window = (seen_sat >= window_size);
      take_cnt    = full_window ? window_size : seen_sat;
      take_idx    = take_cnt - CNT_W'(1);
      sel         = take_idx[IDX_W-1:0];
      emit        = full_window || req_chan.last_sample;
      seen_in     = req_chan.last_sample ? '0 : seen_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            seen_ff <= seen_in;
         end
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_max_ff  <= cell_next[sel];
         rsp_last_ff <= req_chan.last_sample;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.window_max  = rsp_max_ff;
   assign rsp_chan.last_result = rsp_last_ff;

   // a last sample always produces a closing result in the next cycle
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.last_sample |=> rsp_valid_ff && rsp_last_ff)
      else $error("last sample did not yield a closing result");

   // a last sample restarts the count
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.last_sample |=> seen_ff == '0)
      else $error("sequence count not cleared after last sample");

   // count and window size stay in range
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_W'(WINDOW_MAX) && window_size >= CNT_W'(1) &&
      window_size <= CNT_W'(WINDOW_MAX))
      else $error("count or window size out of range");

   // a stalled result is not overwritten by a new sample
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !accept)
      else $error("sample accepted over a pending result");
endmodule
`default_nettype wire

// File: sv/swm_cell.sv
`default_nettype none
// One slot of the max chain: holds the max of the newest k+1 samples.
module swm_cell #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          shift_en,
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   input  wire logic signed [SAMPLE_BITS-1:0] left_max,
   output logic signed [SAMPLE_BITS-1:0]      max_in,
   output logic signed [SAMPLE_BITS-1:0]      max_ff
);
   assign max_in = (sample > left_max) ? sample : left_max;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         max_ff <= max_in;
      end
   end
endmodule
`default_nettype wire

// File: sv/swm_csr.sv
`default_nettype none
module swm_csr #(
   parameter int WINDOW_MAX = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire swm_pkg::csr_addr_type paddr,
   input  wire swm_pkg::csr_data_type pwdata,
   output swm_pkg::csr_data_type      prdata,
   output logic [$clog2(WINDOW_MAX+1)-1:0] window_size
);
   import swm_pkg::*;

   localparam int CNT_W = $clog2(WINDOW_MAX+1);

   logic [CNT_W-1:0] window_size_ff;
   logic [CNT_W-1:0] window_size_in;
   logic             wr_en;
   csr_reg_type      reg_sel;

   assign reg_sel = csr_decode(paddr);
   assign wr_en   = psel && penable && pwrite && (reg_sel == REG_WINDOW_SIZE);

   // zero maps to one, oversize saturates
   always_comb begin
      if (pwdata == '0) begin
         window_size_in = CNT_W'(1);
      end else if (pwdata > CSR_DATA_W'(WINDOW_MAX)) begin
         window_size_in = CNT_W'(WINDOW_MAX);
      end else begin
         window_size_in = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= CNT_W'(1);
      end else if (wr_en) begin
         window_size_ff <= window_size_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_WINDOW_SIZE: prdata = CSR_DATA_W'(window_size_ff);
         default:         prdata = '0;
      endcase
   end

   assign window_size = window_size_ff;
endmodule
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import swm_pkg::*;

   localparam int SAMPLE_BITS = 16;
   localparam int WINDOW_DEPTH = 64;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam csr_addr_type WINDOW_ADDR = {REG_WINDOW_SIZE, 2'b00};
   localparam csr_addr_type UNUSED_ADDR = {REG_UNUSED, 2'b00};
   // covers the result register after the last sample, plus margin
   localparam int DRAIN_CYCLES = 4;
   // ~1k beats, worst gap + worst stall each, config traffic; taken several times over
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_BEATS = 60;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] window_max;
      logic                          last_result;
   } window_result_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   csr_addr_type csr_paddr;
   csr_data_type csr_pwdata;
   csr_data_type csr_prdata;
   logic csr_pready;

   swm_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus (clock);
   swm_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus (clock);

   sliding_window_maximum #(
      .WINDOW_MAX (WINDOW_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_bus),
      .rsp_chan   (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // ---------------------------------------------------------------
   // Predictor state: our own copy of the sample history, the count of
   // the open sequence, its running max and the active window length.
   // ---------------------------------------------------------------
   logic signed [SAMPLE_BITS-1:0] sample_history [WINDOW_DEPTH];
   int                            seq_count;
   logic signed [SAMPLE_BITS-1:0] seq_max;
   int                            window_len;

   window_result_type pending_max[$];   // expected results, oldest first
   window_result_type oldest_max;
   int error_count;
   int cycle_count;
   int beats_sent;
   int hold_cycles;                  // long receiver hold-off request
   bit tx_gaps_on;
   bit rx_stall_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Timeout watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top NOT OK");
      $finish;
   end

   // Shift in one accepted sample and queue the result it should produce.
   // The history array is never cleared: only entries of the open sequence
   // are looked at since seq_count gates the window.
   function automatic void predict_window_max(input logic signed [SAMPLE_BITS-1:0] s,
                                              input logic last);
      logic signed [SAMPLE_BITS-1:0] best;
      for (int i = WINDOW_DEPTH - 1; i > 0; i--)
         sample_history[i] = sample_history[i-1];
      sample_history[0] = s;
      if (seq_count < WINDOW_DEPTH)
         seq_count++;
      if (s > seq_max)
         seq_max = s;
      if (seq_count >= window_len) begin
         best = sample_history[0];
         for (int i = 1; i < window_len; i++)
            if (sample_history[i] > best)
               best = sample_history[i];
         pending_max.push_back('{window_max: best, last_result: last});
      end else if (last) begin
         // short sequence: max over everything seen
         pending_max.push_back('{window_max: seq_max, last_result: 1'b1});
      end
      if (last) begin
         seq_count = 0;
         seq_max = SAMPLE_MIN;
      end
   endfunction

   // Beat monitor: predict on each accepted sample, check each accepted result.
   // Prediction goes first so a same-cycle result would still find its entry.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            predict_window_max(req_bus.sample, req_bus.last_sample);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_max.size() == 0) begin
               $error("window_max: no result expected, got %0d (last_result %0b)",
                      rsp_bus.window_max, rsp_bus.last_result);
               error_count++;
            end else begin
               oldest_max = pending_max.pop_front();
               if (rsp_bus.window_max !== oldest_max.window_max) begin
                  $error("window_max: expected %0d, got %0d",
                         oldest_max.window_max, rsp_bus.window_max);
                  error_count++;
               end
               if (rsp_bus.last_result !== oldest_max.last_result) begin
                  $error("last_result: expected %0b, got %0b",
                         oldest_max.last_result, rsp_bus.last_result);
                  error_count++;
               end
            end
         end
      end
   end

   // Result receiver: random stalls, optional long hold-off on request.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end else if (!rx_stall_on) begin
            rsp_bus.ready = 1'b1;
         end else if ($urandom_range(0, 99) < 3) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(5, 30)) @(negedge clock);
         end else begin
            rsp_bus.ready = ($urandom_range(0, 99) >= 30);
         end
      end
   end

   // mostly back-to-back, some short gaps, rare long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // extremes, a narrow band near zero (lots of ties), otherwise full range
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_TOP;
         1: return SAMPLE_MIN;
         2, 3, 4: return SAMPLE_BITS'(int'($urandom_range(0, 15)) - 8);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // Send one sample beat. Entered and left at a falling edge; valid stays
   // high on exit so a following call can go back-to-back.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
      int gap;
      gap = tx_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.sample = s;
      req_bus.last_sample = last;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_sequence(input int length, input bit terminate);
      for (int k = 0; k < length; k++)
         send_sample(pick_sample(), terminate && (k == length - 1));
   endtask

   // Stop sending, let all expected results drain, then cover the latency
   // in case the last beat made no result but is still in flight.
   task automatic wait_idle();
      req_bus.valid = 1'b0;
      while (pending_max.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_addr_type addr, input csr_data_type data);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic read_csr(input csr_addr_type addr, output csr_data_type data);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = addr;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic check_window_reg();
      csr_data_type readback;
      read_csr(WINDOW_ADDR, readback);
      if (readback !== csr_data_type'(window_len)) begin
         $error("window_size: expected %0d, got %0d", window_len, readback);
         error_count++;
      end
   endtask

   // Write the window length; zero reads as 1, anything past the depth as the depth.
   task automatic set_window(input int unsigned value);
      write_csr(WINDOW_ADDR, csr_data_type'(value));
      if (value == 0)
         window_len = 1;
      else if (value > WINDOW_DEPTH)
         window_len = WINDOW_DEPTH;
      else
         window_len = value;
      check_window_reg();
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Reset window of 1: every beat echoes its own sample. Full-scale values.
   task automatic test_extremes();
      check_window_reg();
      send_sample(SAMPLE_TOP, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(-1, 1'b1);
      send_sample(0, 1'b0);
      send_sample(1, 1'b1);
      wait_idle();
   endtask

   // Sequences that end before the window fills: one result from the running max.
   task automatic test_short_sequences();
      set_window(8);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(5, 1'b0);
      send_sample(-3, 1'b0);
      send_sample(7, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      wait_idle();
   endtask

   // Clamping of the window register, the unused word, and a window that is
   // full exactly on the closing sample.
   task automatic test_window_limits();
      set_window(0);
      set_window(127);
      set_window(65);
      write_csr(UNUSED_ADDR, 32'd3);
      check_window_reg();
      set_window(64);
      set_window(2);
      send_sample(10, 1'b0);
      send_sample(-20, 1'b1);
      send_sample(3, 1'b0);
      send_sample(9, 1'b0);
      send_sample(-1, 1'b0);
      send_sample(-5, 1'b1);
      wait_idle();
   endtask

   // Shrink the window while a sequence is open: the new length is compared
   // against the samples already counted.
   task automatic test_resize_midsequence();
      set_window(4);
      send_sample(1, 1'b0);
      send_sample(2, 1'b0);
      wait_idle();
      set_window(2);
      send_sample(0, 1'b0);
      send_sample(-7, 1'b1);
      wait_idle();
   endtask

   // Receiver holds off for a long stretch while beats keep coming, so the
   // output register fills and the input gets throttled.
   task automatic test_backpressure();
      set_window(1);
      tx_gaps_on = 1'b0;
      hold_cycles = 150;
      send_sequence(40, 1'b1);
      wait_idle();
      tx_gaps_on = 1'b1;
   endtask

   // Random phases: a window setting per phase, mostly well-formed sequences
   // with random content, some short ones and some left open into the next
   // phase (so the window changes mid-sequence).
   task automatic test_random();
      int phase_start;
      int kind;
      int length;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0: set_window(0);
            1: set_window(127);
            2: set_window(64);
            3: set_window($urandom_range(16, 63));
            4: set_window(1);
            default: set_window($urandom_range(2, 8));
         endcase
         // some phases run without any idling at all
         tx_gaps_on = ($urandom_range(0, 3) != 0);
         rx_stall_on = ($urandom_range(0, 3) != 0);
         phase_start = beats_sent;
         while (beats_sent - phase_start < PHASE_BEATS) begin
            kind = $urandom_range(0, 9);
            if (kind < 3 && window_len > 1) begin
               length = $urandom_range(1, window_len - 1);
               send_sequence(length, 1'b1);
            end else if (kind < 9) begin
               length = $urandom_range(window_len, window_len + 12);
               send_sequence(length, 1'b1);
            end else begin
               // unterminated run, merges into whatever follows
               send_sequence($urandom_range(1, 20), 1'b0);
            end
         end
         if ($urandom_range(0, 2) == 0)
            send_sequence($urandom_range(1, 6), 1'b0);
         wait_idle();
      end
      tx_gaps_on = 1'b1;
      rx_stall_on = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      req_bus.last_sample = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      error_count = 0;
      beats_sent = 0;
      hold_cycles = 0;
      tx_gaps_on = 1'b1;
      rx_stall_on = 1'b1;
      window_len = 1;
      seq_count = 0;
      seq_max = SAMPLE_MIN;
      for (int i = 0; i < WINDOW_DEPTH; i++)
         sample_history[i] = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_short_sequences();
      test_window_limits();
      test_resize_midsequence();
      test_backpressure();
      test_random();

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
sv/swm_pkg.sv
sv/swm_if.sv
sv/swm_cell.sv
sv/swm_csr.sv
sv/sliding_window_maximum.sv
dv/tb_top.sv
